### hw/rtl/http_chunked_decoder_macros.svh
// Assertion helpers shared by the decoder RTL.
`ifndef HTTP_CHUNKED_DECODER_MACROS_SVH
`define HTTP_CHUNKED_DECODER_MACROS_SVH

// Same-cycle implication, checked outside of reset.
`define HCD_ASSERT_IMP(lbl, clk, rstn, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked outside of reset.
`define HCD_ASSERT_NXT(lbl, clk, rstn, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error(msg);

`endif

### hw/rtl/hcd_pkg.sv
package hcd_pkg;

    // Default width of the chunk size accumulator.
    localparam int HCD_SIZE_BITS = 31;

    // Characters the parser looks for.
    localparam logic [7:0] CH_CR    = 8'h0D;
    localparam logic [7:0] CH_LF    = 8'h0A;
    localparam logic [7:0] CH_TAB   = 8'h09;
    localparam logic [7:0] CH_VT    = 8'h0B;
    localparam logic [7:0] CH_FF    = 8'h0C;
    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_PLUS  = 8'h2B;
    localparam logic [7:0] CH_MINUS = 8'h2D;
    localparam logic [7:0] CH_ZERO  = 8'h30;
    localparam logic [7:0] CH_NINE  = 8'h39;
    localparam logic [7:0] CH_UA    = 8'h41;
    localparam logic [7:0] CH_UF    = 8'h46;
    localparam logic [7:0] CH_UX    = 8'h58;
    localparam logic [7:0] CH_LA    = 8'h61;
    localparam logic [7:0] CH_LF_HEX = 8'h66;
    localparam logic [7:0] CH_LX    = 8'h78;

    // Parser phase, one-hot.
    typedef enum logic [7:0] {
        PH_START    = 8'b0000_0001,
        PH_WS       = 8'b0000_0010,
        PH_SIGN     = 8'b0000_0100,
        PH_DIGITS   = 8'b0000_1000,
        PH_IGNORE   = 8'b0001_0000,
        PH_PAYLOAD  = 8'b0010_0000,
        PH_TRAIL    = 8'b0100_0000,
        PH_TRAIL_CR = 8'b1000_0000
    } phase_t;

    // Completion status reported with the last byte.
    typedef enum logic [1:0] {
        ST_CLEAN     = 2'd0,
        ST_STOPPED   = 2'd1,
        ST_LINE_OPEN = 2'd2,
        ST_TRUNCATED = 2'd3
    } status_t;

    // One result item as it travels from the parser to the output register.
    typedef struct packed {
        logic [7:0] data;
        logic       pay;
        logic       done;
        status_t    status;
    } result_t;

    // Hex digit value; bit 4 set means the byte is not a hex digit.
    function automatic logic [4:0] hex_val(input logic [7:0] c);
        logic [4:0] v;
        v = 5'h10;
        if (c >= CH_ZERO && c <= CH_NINE) begin
            v = {1'b0, 4'(c - CH_ZERO)};
        end else if (c >= CH_LA && c <= CH_LF_HEX) begin
            v = {1'b0, 4'(c - CH_LA + 8'd10)};
        end else if (c >= CH_UA && c <= CH_UF) begin
            v = {1'b0, 4'(c - CH_UA + 8'd10)};
        end
        return v;
    endfunction

    // Whitespace as the C library classifies it.
    function automatic logic is_space(input logic [7:0] c);
        return c == CH_SPACE || c == CH_TAB || c == CH_LF || c == CH_VT ||
               c == CH_FF || c == CH_CR;
    endfunction

endpackage

### hw/rtl/hcd_parser.sv
`include "http_chunked_decoder_macros.svh"

module hcd_parser
    import hcd_pkg::*;
#(
    parameter int SIZE_BITS = HCD_SIZE_BITS
) (
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       accept,
    input  logic [7:0] in_byte,
    input  logic       in_last,
    output logic       produce,
    output result_t    res
);

    typedef struct packed {
        phase_t                 ph;
        logic [SIZE_BITS-1:0]   acc;
        logic                   neg;
        logic                   dig;
    } line_t;

    phase_t               phase_reg, phase_next;
    logic [SIZE_BITS-1:0] acc_reg, acc_next;
    logic [SIZE_BITS-1:0] rem_reg, rem_next;
    logic                 neg_reg, neg_next;
    logic                 dig_reg, dig_next;
    logic                 pcr_reg, pcr_next;
    logic                 stop_reg, stop_next;

    // Line-byte path signals.
    phase_t               lb_start_ph;
    line_t                lb_s0;
    line_t                lb_s1;
    line_t                lb_s2;
    logic                 lb_endl;
    logic                 lb_pcr;
    logic                 pay;
    logic [SIZE_BITS-1:0] rem_dec;
    status_t              status;

    // Append one hex digit, saturating at all ones.
    function automatic line_t accum(input line_t s, input logic [3:0] d);
        line_t r;
        r = s;
        if (s.acc[SIZE_BITS-1 -: 4] != 4'd0) begin
            r.acc = '1;
        end else begin
            r.acc = {s.acc[SIZE_BITS-5:0], d};
        end
        r.dig = 1'b1;
        r.ph  = PH_DIGITS;
        return r;
    endfunction

    // Handling after an optional sign: leading zero, 0x prefix or digits.
    function automatic line_t after_sign(input line_t s, input logic [7:0] c);
        line_t      r;
        logic [4:0] hv;
        r  = s;
        hv = hex_val(c);
        priority if (!s.dig && c == CH_ZERO) begin
            r.dig = 1'b1;
            r.ph  = PH_SIGN;
        end else if (s.dig && (c == CH_LX || c == CH_UX)) begin
            r.ph = PH_DIGITS;
        end else if (!hv[4]) begin
            r = accum(s, hv[3:0]);
        end else begin
            r.ph = PH_IGNORE;
        end
        return r;
    endfunction

    // One ordinary character of a size line.
    function automatic line_t line_char(input line_t s, input logic [7:0] c);
        line_t      r;
        logic [4:0] hv;
        r  = s;
        hv = hex_val(c);
        unique case (s.ph)
            PH_START, PH_WS: begin
                priority if (is_space(c)) begin
                    r.ph = PH_WS;
                end else if (c == CH_PLUS || c == CH_MINUS) begin
                    r.neg = (c == CH_MINUS);
                    r.ph  = PH_SIGN;
                end else begin
                    r = after_sign(s, c);
                end
            end
            PH_SIGN: begin
                r = after_sign(s, c);
            end
            PH_DIGITS: begin
                if (!hv[4]) begin
                    r = accum(s, hv[3:0]);
                end else begin
                    r.ph = PH_IGNORE;
                end
            end
            default: begin
            end
        endcase
        return r;
    endfunction

    // Size-line byte: resolve a pending CR first, then the byte itself.
    always_comb begin
        priority case (phase_reg)
            PH_TRAIL:    lb_start_ph = PH_START;
            PH_TRAIL_CR: lb_start_ph = PH_WS;
            default:     lb_start_ph = phase_reg;
        endcase
        lb_s0   = '{ph: lb_start_ph, acc: acc_reg, neg: neg_reg, dig: dig_reg};
        lb_endl = pcr_reg && (in_byte == CH_LF);
        lb_s1   = (pcr_reg && !lb_endl) ? line_char(lb_s0, CH_CR) : lb_s0;
        lb_s2   = (lb_endl || in_byte == CH_CR) ? lb_s1 : line_char(lb_s1, in_byte);
        lb_pcr  = !lb_endl && (in_byte == CH_CR);
    end

    assign rem_dec = (rem_reg != '0) ? rem_reg - SIZE_BITS'(1) : rem_reg;

    // Next state for one accepted byte.
    always_comb begin
        phase_next = phase_reg;
        acc_next   = acc_reg;
        rem_next   = rem_reg;
        neg_next   = neg_reg;
        dig_next   = dig_reg;
        pcr_next   = pcr_reg;
        stop_next  = stop_reg;
        pay        = 1'b0;

        if (!stop_reg) begin
            if (phase_reg == PH_PAYLOAD) begin
                pay      = 1'b1;
                rem_next = rem_dec;
                if (rem_dec == '0) begin
                    phase_next = PH_TRAIL;
                end
            end else if (phase_reg == PH_TRAIL && in_byte == CH_CR) begin
                phase_next = PH_TRAIL_CR;
            end else if (phase_reg == PH_TRAIL_CR && in_byte == CH_LF) begin
                phase_next = PH_START;
            end else if (lb_endl) begin
                // End of a size line: start a chunk or stop.
                pcr_next = 1'b0;
                acc_next = '0;
                neg_next = 1'b0;
                dig_next = 1'b0;
                if (!dig_reg || neg_reg || acc_reg == '0) begin
                    stop_next  = 1'b1;
                    phase_next = lb_start_ph;
                end else begin
                    rem_next   = acc_reg;
                    phase_next = PH_PAYLOAD;
                end
            end else begin
                phase_next = lb_s2.ph;
                acc_next   = lb_s2.acc;
                neg_next   = lb_s2.neg;
                dig_next   = lb_s2.dig;
                pcr_next   = lb_pcr;
            end
        end

        // Status of the body as it stands after this byte.
        priority if (stop_next) begin
            status = ST_STOPPED;
        end else if (phase_next == PH_PAYLOAD) begin
            status = ST_TRUNCATED;
        end else if (phase_next == PH_TRAIL) begin
            status = ST_CLEAN;
        end else if (phase_next == PH_START && !pcr_next) begin
            status = ST_CLEAN;
        end else begin
            status = ST_LINE_OPEN;
        end
    end

    // Result item for this byte.
    assign produce    = pay || in_last;
    assign res.data   = pay ? in_byte : 8'd0;
    assign res.pay    = pay;
    assign res.done   = in_last;
    assign res.status = in_last ? status : ST_CLEAN;

    // Parser state; the last byte of a body returns it to the reset values.
    always_ff @(posedge aclk) begin
        if (!aresetn || (accept && in_last)) begin
            phase_reg <= PH_START;
            acc_reg   <= '0;
            rem_reg   <= '0;
            neg_reg   <= 1'b0;
            dig_reg   <= 1'b0;
            pcr_reg   <= 1'b0;
            stop_reg  <= 1'b0;
        end else if (accept) begin
            phase_reg <= phase_next;
            acc_reg   <= acc_next;
            rem_reg   <= rem_next;
            neg_reg   <= neg_next;
            dig_reg   <= dig_next;
            pcr_reg   <= pcr_next;
            stop_reg  <= stop_next;
        end
    end

    `HCD_ASSERT_IMP(a_payload_rem_nonzero, aclk, aresetn, phase_reg == PH_PAYLOAD, rem_reg != '0, "payload phase with nothing remaining")
    `HCD_ASSERT_IMP(a_no_payload_after_stop, aclk, aresetn, accept && stop_reg, !res.pay, "payload byte emitted after a stop")

endmodule

### hw/rtl/hcd_out_slice.sv
`include "http_chunked_decoder_macros.svh"

module hcd_out_slice
    import hcd_pkg::*;
(
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       load,
    input  result_t    res,
    output logic       can_take,
    output logic       m_valid,
    input  logic       m_ready,
    output logic [7:0] m_out_byte,
    output logic       m_out_valid,
    output logic       m_out_done,
    output logic [1:0] m_out_status
);

    logic    valid_reg, valid_next;
    result_t res_reg;

    // A new item may enter when the register is empty or drains this cycle.
    assign can_take = !valid_reg || m_ready;

    always_comb begin
        valid_next = valid_reg;
        if (load) begin
            valid_next = 1'b1;
        end else if (m_ready) begin
            valid_next = 1'b0;
        end
    end

    // Result register control.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    // Result register payload.
    always_ff @(posedge aclk) begin
        if (load) begin
            res_reg <= res;
        end
    end

    assign m_valid      = valid_reg;
    assign m_out_byte   = res_reg.data;
    assign m_out_valid  = res_reg.pay;
    assign m_out_done   = res_reg.done;
    assign m_out_status = res_reg.status;

    `HCD_ASSERT_IMP(a_load_has_room, aclk, aresetn, load, !valid_reg || m_ready, "result overwritten before transfer")
    `HCD_ASSERT_NXT(a_load_shows, aclk, aresetn, load, m_valid, "loaded result not presented")
    `HCD_ASSERT_IMP(a_empty_is_last, aclk, aresetn, m_valid && !m_out_valid, m_out_done && m_out_byte == 8'd0, "result without payload is not a clean last marker")

endmodule

### hw/rtl/http_chunked_decoder.sv
// Channel  | Handshake          | Payload
// ---------+--------------------+------------------------------------------------
// input    | s_valid / s_ready  | s_in_byte[7:0], s_in_last
// result   | m_valid / m_ready  | m_out_byte[7:0], m_out_valid, m_out_done,
//          |                    | m_out_status[1:0]
//
// One byte is accepted per cycle while s_ready is high; the parser state updates in the same cycle.
// A result appears in the cycle after its byte, from the result register.
// s_ready falls only while the result register is full and m_ready is low.
// aresetn is synchronous and active low; it clears the parser and empties the
// result register. The last byte of a body also returns the parser to reset.
module http_chunked_decoder
    import hcd_pkg::*;
#(
    parameter int SIZE_BITS = HCD_SIZE_BITS
) (
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       s_valid,
    output logic       s_ready,
    input  logic [7:0] s_in_byte,
    input  logic       s_in_last,
    output logic       m_valid,
    input  logic       m_ready,
    output logic [7:0] m_out_byte,
    output logic       m_out_valid,
    output logic       m_out_done,
    output logic [1:0] m_out_status
);

    logic    accept;
    logic    produce;
    logic    can_take;
    result_t res;

    // Input transfer and load of the result register.
    assign s_ready = can_take;
    assign accept  = s_valid && can_take;

    hcd_parser #(
        .SIZE_BITS (SIZE_BITS)
    ) u_parser (
        .aclk    (aclk),
        .aresetn (aresetn),
        .accept  (accept),
        .in_byte (s_in_byte),
        .in_last (s_in_last),
        .produce (produce),
        .res     (res)
    );

    hcd_out_slice u_out (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .load         (accept && produce),
        .res          (res),
        .can_take     (can_take),
        .m_valid      (m_valid),
        .m_ready      (m_ready),
        .m_out_byte   (m_out_byte),
        .m_out_valid  (m_out_valid),
        .m_out_done   (m_out_done),
        .m_out_status (m_out_status)
    );

endmodule
